// ----- rtl/core/framed_packet_receiver_checker_top_defines.svh -----
// ----------------------------------------------------------------------------
// Framed packet receiver checker assertion macros
// Shared assertion forms for the receiver checker, clocked on the rising edge
// and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_CHECKER_TOP_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_CHECKER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fprc_pkg.sv -----
// ----------------------------------------------------------------------------
// Framed packet receiver checker package
// Byte role and verdict codes, register decode and the beat types passed
// between the front end, the back end and the queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fprc_pkg;

  localparam logic [2:0] ROLE_SYNC1   = 3'd0;
  localparam logic [2:0] ROLE_SYNC2   = 3'd1;
  localparam logic [2:0] ROLE_DESC    = 3'd2;
  localparam logic [2:0] ROLE_LEN     = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
  localparam logic [2:0] ROLE_CK_MSB  = 3'd5;
  localparam logic [2:0] ROLE_CK_LSB  = 3'd6;

  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_HEADER   = 2'd1;
  localparam logic [1:0] VERDICT_CHECKSUM = 2'd2;
  localparam logic [1:0] VERDICT_FIELD    = 2'd3;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  localparam logic [7:0] HEADER_FIRST_RESET  = 8'h75;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'h65;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] role;
    logic       fstart;
    logic       hdr_err;
    logic       fld_err;
    logic [7:0] desc;
    logic [7:0] len;
  } fprc_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] role;
    logic       fstart;
    logic       done;
    logic [1:0] verdict;
    logic [7:0] desc;
    logic [7:0] len;
  } fprc_result_t;

endpackage

// ----- rtl/core/fprc_fifo.sv -----
// ----------------------------------------------------------------------------
// Framed packet receiver checker two-entry queue
// Small first-in first-out buffer that decouples a producer and a consumer
// and sustains one beat per cycle in both directions while it is not full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fprc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             wr_ok;
  logic             rd_ok;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_ok) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_ok) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (wr_ok && !rd_ok) begin
        count_r <= count_r + 2'd1;
      end else if (rd_ok && !wr_ok) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/fprc_front.sv -----
// ----------------------------------------------------------------------------
// Framed packet receiver checker front end
// Tracks packet framing, classifies every received byte by its role, marks
// field starts and collects header and field errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fprc_front
  import fprc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic [7:0] header_first,
  input  logic [7:0] header_second,
  output fprc_beat_t beat
);

  logic [2:0] phase_r;
  logic [2:0] phase_nxt;
  logic [7:0] payload_left_r;
  logic [7:0] payload_left_nxt;
  logic [7:0] field_left_r;
  logic [7:0] field_left_nxt;
  logic       hdr_err_r;
  logic       hdr_err_nxt;
  logic       fld_err_r;
  logic       fld_err_nxt;
  logic [7:0] desc_r;
  logic [7:0] desc_nxt;
  logic [7:0] len_r;
  logic [7:0] len_nxt;
  logic [2:0] role;
  logic       fstart;

  assign role = (phase_r > ROLE_CK_LSB) ? ROLE_SYNC1 : phase_r;

  always_comb begin
    phase_nxt        = phase_r;
    payload_left_nxt = payload_left_r;
    field_left_nxt   = field_left_r;
    hdr_err_nxt      = hdr_err_r;
    fld_err_nxt      = fld_err_r;
    desc_nxt         = desc_r;
    len_nxt          = len_r;
    fstart           = 1'b0;
    case (role)
      ROLE_SYNC1: begin
        fld_err_nxt = 1'b0;
        desc_nxt    = 8'd0;
        len_nxt     = 8'd0;
        hdr_err_nxt = (rx_byte != header_first);
        phase_nxt   = ROLE_SYNC2;
      end
      ROLE_SYNC2: begin
        if (rx_byte != header_second) begin
          hdr_err_nxt = 1'b1;
        end
        phase_nxt = ROLE_DESC;
      end
      ROLE_DESC: begin
        desc_nxt  = rx_byte;
        phase_nxt = ROLE_LEN;
      end
      ROLE_LEN: begin
        len_nxt          = rx_byte;
        payload_left_nxt = rx_byte;
        field_left_nxt   = 8'd0;
        phase_nxt        = (rx_byte == 8'd0) ? ROLE_CK_MSB : ROLE_PAYLOAD;
      end
      ROLE_PAYLOAD: begin
        if (field_left_r == 8'd0) begin
          fstart = 1'b1;
          if (rx_byte == 8'd0 || rx_byte > payload_left_r) begin
            fld_err_nxt = 1'b1;
          end
          field_left_nxt = (rx_byte == 8'd0) ? 8'd0 : rx_byte - 8'd1;
        end else begin
          field_left_nxt = field_left_r - 8'd1;
        end
        if (payload_left_r != 8'd0) begin
          payload_left_nxt = payload_left_r - 8'd1;
        end
        if (payload_left_nxt == 8'd0) begin
          phase_nxt = ROLE_CK_MSB;
        end
      end
      ROLE_CK_MSB: begin
        phase_nxt = ROLE_CK_LSB;
      end
      default: begin
        phase_nxt = ROLE_SYNC1;
      end
    endcase
  end

  always_comb begin
    beat.data    = rx_byte;
    beat.role    = role;
    beat.fstart  = fstart;
    beat.hdr_err = hdr_err_nxt;
    beat.fld_err = fld_err_nxt;
    beat.desc    = desc_nxt;
    beat.len     = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ROLE_SYNC1;
      payload_left_r <= 8'd0;
      field_left_r   <= 8'd0;
      hdr_err_r      <= 1'b0;
      fld_err_r      <= 1'b0;
      desc_r         <= 8'd0;
      len_r          <= 8'd0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      payload_left_r <= payload_left_nxt;
      field_left_r   <= field_left_nxt;
      hdr_err_r      <= hdr_err_nxt;
      fld_err_r      <= fld_err_nxt;
      desc_r         <= desc_nxt;
      len_r          <= len_nxt;
    end
  end

endmodule

// ----- rtl/core/fprc_back.sv -----
// ----------------------------------------------------------------------------
// Framed packet receiver checker back end
// Keeps the two running checksum sums, captures the checksum high byte and
// builds the result beat with the packet verdict on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fprc_back
  import fprc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         beat_valid,
  input  fprc_beat_t   beat,
  output logic         beat_pop,
  input  logic         res_full,
  output logic         res_push,
  output fprc_result_t res
);

  logic [7:0] sum_first_r;
  logic [7:0] sum_first_nxt;
  logic [7:0] sum_second_r;
  logic [7:0] sum_second_nxt;
  logic [7:0] ck_msb_r;
  logic [7:0] ck_msb_nxt;
  logic       step;
  logic       done;
  logic [1:0] verdict;

  assign step     = beat_valid && !res_full;
  assign beat_pop = step;
  assign res_push = step;

  always_comb begin
    sum_first_nxt  = sum_first_r;
    sum_second_nxt = sum_second_r;
    ck_msb_nxt     = ck_msb_r;
    done           = 1'b0;
    verdict        = VERDICT_OK;
    if (beat.role == ROLE_SYNC1) begin
      sum_first_nxt  = beat.data;
      sum_second_nxt = beat.data;
    end else if (beat.role inside {ROLE_SYNC2, ROLE_DESC, ROLE_LEN, ROLE_PAYLOAD}) begin
      sum_first_nxt  = sum_first_r + beat.data;
      sum_second_nxt = sum_second_r + sum_first_nxt;
    end else if (beat.role == ROLE_CK_MSB) begin
      ck_msb_nxt = beat.data;
    end else begin
      done = 1'b1;
      if (beat.hdr_err) begin
        verdict = VERDICT_HEADER;
      end else if (ck_msb_r != sum_first_r || beat.data != sum_second_r) begin
        verdict = VERDICT_CHECKSUM;
      end else if (beat.fld_err) begin
        verdict = VERDICT_FIELD;
      end
    end
  end

  always_comb begin
    res.data    = beat.data;
    res.role    = beat.role;
    res.fstart  = beat.fstart;
    res.done    = done;
    res.verdict = verdict;
    res.desc    = beat.desc;
    res.len     = beat.len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_first_r  <= 8'd0;
      sum_second_r <= 8'd0;
      ck_msb_r     <= 8'd0;
    end else if (step) begin
      sum_first_r  <= sum_first_nxt;
      sum_second_r <= sum_second_nxt;
      ck_msb_r     <= ck_msb_nxt;
    end
  end

endmodule

// ----- rtl/core/framed_packet_receiver_checker_top.sv -----
// ----------------------------------------------------------------------------
// Framed packet receiver checker top level
// Receives back-to-back framed packets one byte per beat, echoes every byte
// with its role and reports a checksum and framing verdict per packet.
// ----------------------------------------------------------------------------
// Usage:
// The input side is a queue write port: a byte is taken on a rising edge
// with push high and full low. The result side is a queue read port: while
// empty is low the oldest result beat is on the out_ ports, and it leaves on
// a rising edge with pop high. Every input byte yields exactly one result.
// The front end classifies a byte in the cycle it is taken and stores it in a
// two-entry queue; the back end adds it to the sums and writes the result
// queue. Each part handles one beat per cycle, so one byte per cycle is
// sustained while the reader keeps up. When the reader stalls, the result
// queue fills, then the middle queue, and full rises; nothing is lost. The
// APB port sets the expected sync bytes and must be written only while the
// block is idle; the block itself does not enforce this. Synchronous reset
// empties both queues, restores the sync bytes to 0x75 and 0x65 and makes
// the next byte the first sync byte of a packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "framed_packet_receiver_checker_top_defines.svh"

module framed_packet_receiver_checker_top
  import fprc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_rx_byte,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_data_byte,
  output logic [2:0]        out_byte_role,
  output logic              out_field_start,
  output logic              out_packet_done,
  output logic [1:0]        out_verdict,
  output logic [7:0]        out_descriptor,
  output logic [7:0]        out_payload_size,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]   header_first_r;
  logic [7:0]   header_second_r;
  logic         cfg_write;
  logic         in_accept;
  fprc_beat_t   front_beat;
  fprc_beat_t   mid_beat;
  logic         mid_full;
  logic         mid_empty;
  logic         mid_pop;
  fprc_result_t back_res;
  fprc_result_t out_res;
  logic         res_full;
  logic         res_push;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_HEADER_SECOND) ? {24'd0, header_second_r}
                                                     : {24'd0, header_first_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= HEADER_FIRST_RESET;
      header_second_r <= HEADER_SECOND_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_HEADER_FIRST) begin
        header_first_r <= pwdata[7:0];
      end else begin
        header_second_r <= pwdata[7:0];
      end
    end
  end

  assign full      = mid_full;
  assign in_accept = push && !mid_full;

  fprc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .rx_byte       (in_rx_byte),
    .header_first  (header_first_r),
    .header_second (header_second_r),
    .beat          (front_beat)
  );

  fprc_fifo #(
    .WIDTH ($bits(fprc_beat_t))
  ) u_mid_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept),
    .wr_data (front_beat),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_beat),
    .empty   (mid_empty)
  );

  fprc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (!mid_empty),
    .beat       (mid_beat),
    .beat_pop   (mid_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res)
  );

  fprc_fifo #(
    .WIDTH ($bits(fprc_result_t))
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

  assign out_data_byte    = out_res.data;
  assign out_byte_role    = out_res.role;
  assign out_field_start  = out_res.fstart;
  assign out_packet_done  = out_res.done;
  assign out_verdict      = out_res.verdict;
  assign out_descriptor   = out_res.desc;
  assign out_payload_size = out_res.len;

  `FPRC_ASSERT_SAME(a_verdict_only_when_done, clk, rst_n,
    !empty && !out_packet_done, out_verdict == VERDICT_OK,
    "verdict set on a beat that does not end a packet")

  `FPRC_ASSERT_SAME(a_done_on_checksum_lsb, clk, rst_n,
    !empty && out_packet_done, out_byte_role == ROLE_CK_LSB,
    "packet done on a beat that is not the checksum low byte")

  `FPRC_ASSERT_SAME(a_field_start_in_payload, clk, rst_n,
    !empty && out_field_start, out_byte_role == ROLE_PAYLOAD,
    "field start marked outside the payload")

  `FPRC_ASSERT_SAME(a_sync_clears_holds, clk, rst_n,
    !empty && out_byte_role == ROLE_SYNC1,
    out_descriptor == 8'd0 && out_payload_size == 8'd0,
    "descriptor or length not cleared on the first sync byte")

endmodule
